/* rtl/core/rgb_to_hsi_converter_defines.svh */
// Assertion macros used by the converter's top-level RTL.
`ifndef RGB_TO_HSI_CONVERTER_DEFINES_SVH
`define RGB_TO_HSI_CONVERTER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RTHSI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain condition that must hold whenever the qualifier is high.
`define RTHSI_ASSERT_WHEN(lbl, clk, rst, qual, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (qual) |-> (cond)) else $error(msg);

`endif

/* rtl/core/rthsi_pkg.sv */
package rthsi_pkg;

   localparam int XW = 30;          // CORDIC vector width, 16 fraction bits
   localparam int ZW = 32;          // angle accumulator, 2^-22 degree units
   localparam int NW = 26;          // saturation dividend width
   localparam int QW = 16;          // saturation quotient width
   localparam int NumCells = 24;

   localparam logic signed [XW-1:0] Sqrt3Q16 = XW'(113512);
   localparam logic signed [ZW-1:0] HalfTurn = ZW'(754974720);
   localparam logic signed [ZW-1:0] FullTurn = ZW'(1509949440);
   localparam logic [14:0]          HueSteps = 15'd23040;
   localparam logic [17:0]          RecipSix = 18'd174763;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [15:0] saturation;
      logic [15:0] intensity;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [NW-1:0]        rem;
      logic [NW-1:0]        dsr;
      logic [QW-1:0]        quo;
      logic [9:0]           sum;
      logic                 gray;
      logic                 sat_zero;
   } stage_type;

   function automatic logic signed [ZW-1:0] atan_step(input int idx);
      logic signed [ZW-1:0] a;
      case (idx)
         0: a = ZW'(188743680);
         1: a = ZW'(111421900);
         2: a = ZW'(58872272);
         3: a = ZW'(29884485);
         4: a = ZW'(15000234);
         5: a = ZW'(7507429);
         6: a = ZW'(3754631);
         7: a = ZW'(1877430);
         8: a = ZW'(938729);
         9: a = ZW'(469366);
         10: a = ZW'(234683);
         11: a = ZW'(117342);
         12: a = ZW'(58671);
         13: a = ZW'(29335);
         14: a = ZW'(14668);
         15: a = ZW'(7334);
         16: a = ZW'(3667);
         17: a = ZW'(1833);
         18: a = ZW'(917);
         19: a = ZW'(458);
         20: a = ZW'(229);
         21: a = ZW'(115);
         22: a = ZW'(57);
         23: a = ZW'(29);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* rtl/core/rgb_to_hsi_converter.sv */
// RGB to HSI pixel converter.
// A pixel is transferred in at a rising edge where start is high and busy is
// low. Busy never rises, so one pixel can be transferred every cycle.
// Each pixel gives exactly one result: rsp_valid is high for one cycle with
// hue (1/64 degree), saturation (Q1.15) and intensity (Q8.8) on rsp_data.
// The pipeline has one setup stage, 24 CORDIC cells and one output
// stage. Throughput is one pixel per cycle; the row of CORDIC cells, each
// doing one rotation, with the first sixteen also producing one quotient bit
// of saturation, sets the latency.
// Results come out in the order that pixels went in.
// The receiver cannot stall; every result must be taken when it is shown.
// A synchronous reset empties the pipeline; pixels in flight are dropped and
// no result appears until new pixels arrive.
`include "rgb_to_hsi_converter_defines.svh"

module rgb_to_hsi_converter import rthsi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   stage_type chain [NumCells+1];
   logic      accept;

   assign busy = 1'b0;
   assign accept = start && !busy;

   rthsi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      rthsi_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .stage_prev (chain[i]),
         .stage_out  (chain[i+1])
      );
   end

   rthsi_post u_post (
      .clock      (clock),
      .reset      (reset),
      .stage_last (chain[NumCells]),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   `RTHSI_ASSERT(a_latency, clock, reset, accept |-> ##26 rsp_valid, "result missing after transfer")
   `RTHSI_ASSERT(a_no_spurious, clock, reset, !accept |-> ##26 !rsp_valid, "result without transfer")
   `RTHSI_ASSERT_WHEN(a_hue_range, clock, reset, rsp_valid, rsp_data.hue < HueSteps, "hue out of range")
   `RTHSI_ASSERT_WHEN(a_sat_range, clock, reset, rsp_valid, rsp_data.saturation <= 16'd32768, "saturation above one")

endmodule

/* rtl/core/rthsi_prep.sv */
module rthsi_prep import rthsi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output stage_type stage_out
);

   stage_type            stage_ff, stage_in;
   logic signed [9:0]    dx;
   logic signed [XW-1:0] dy;
   logic signed [XW-1:0] x0, y0;
   logic [9:0]           sum, mn;

   always_comb begin
      dx = 10'($signed({2'b00, req_data.red, 1'b0}) - $signed({2'b00, req_data.green})
           - $signed({2'b00, req_data.blue}));
      dy = XW'($signed({1'b0, req_data.green}) - $signed({1'b0, req_data.blue}));
      x0 = {{(XW-26){dx[9]}}, dx, 16'b0};
      y0 = XW'(dy * Sqrt3Q16);
      sum = 10'(req_data.red) + 10'(req_data.green) + 10'(req_data.blue);
      mn = 10'(req_data.red);
      if (10'(req_data.green) < mn) begin
         mn = 10'(req_data.green);
      end
      if (10'(req_data.blue) < mn) begin
         mn = 10'(req_data.blue);
      end

      stage_in.valid = accept;
      // Fold the left half plane onto the right so the CORDIC converges.
      if (x0 < 0) begin
         stage_in.x = -x0;
         stage_in.y = -y0;
         stage_in.z = HalfTurn;
      end else begin
         stage_in.x = x0;
         stage_in.y = y0;
         stage_in.z = '0;
      end
      // Rounded quotient: (2^16*(sum - 3*min) + sum) / (2*sum).
      stage_in.rem = (NW'(sum - 10'(3 * mn)) << 16) + NW'(sum);
      stage_in.dsr = NW'({sum, 1'b0}) << (QW - 1);
      stage_in.quo = '0;
      stage_in.sum = sum;
      stage_in.gray = (req_data.red == req_data.green) && (req_data.red == req_data.blue);
      stage_in.sat_zero = stage_in.gray || (sum < 10'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

/* rtl/core/rthsi_cell.sv */
module rthsi_cell import rthsi_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_prev,
   output stage_type stage_out
);

   stage_type stage_ff, stage_in;

   always_comb begin
      stage_in = stage_prev;
      // One CORDIC rotation toward the x axis.
      if (stage_prev.y >= 0) begin
         stage_in.x = stage_prev.x + (stage_prev.y >>> IDX);
         stage_in.y = stage_prev.y - (stage_prev.x >>> IDX);
         stage_in.z = stage_prev.z + atan_step(IDX);
      end else begin
         stage_in.x = stage_prev.x - (stage_prev.y >>> IDX);
         stage_in.y = stage_prev.y + (stage_prev.x >>> IDX);
         stage_in.z = stage_prev.z - atan_step(IDX);
      end
      // The first cells also produce one saturation quotient bit each.
      if (IDX < QW) begin
         if (stage_prev.rem >= stage_prev.dsr) begin
            stage_in.rem = stage_prev.rem - stage_prev.dsr;
            stage_in.quo = {stage_prev.quo[QW-2:0], 1'b1};
         end else begin
            stage_in.quo = {stage_prev.quo[QW-2:0], 1'b0};
         end
         stage_in.dsr = stage_prev.dsr >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

/* rtl/core/rthsi_post.sv */
module rthsi_post import rthsi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_last,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   logic                 valid_ff;
   rsp_type              data_ff, data_in;
   logic signed [ZW-1:0] zw;
   logic [ZW:0]          zr;
   logic [15:0]          h;
   logic [18:0]          inum;
   logic [36:0]          iprod;

   always_comb begin
      zw = stage_last.z;
      if (zw < 0) begin
         zw = zw + FullTurn;
      end
      if (zw >= FullTurn) begin
         zw = zw - FullTurn;
      end
      zr = (ZW+1)'($unsigned(zw)) + (ZW+1)'(32768);
      h = zr[31:16];
      // An angle that rounds up to a full turn wraps to zero.
      if (h >= 16'(HueSteps)) begin
         h = h - 16'(HueSteps);
      end
      data_in.hue = stage_last.gray ? '0 : h[14:0];
      data_in.saturation = stage_last.sat_zero ? '0 : stage_last.quo;
      // Division by six through a reciprocal, exact over this range.
      inum = {stage_last.sum, 9'b0} + 19'd3;
      iprod = 37'(inum) * 37'(RecipSix);
      data_in.intensity = iprod[35:20];
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_last.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule
